[rtl/pss_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_pkg
// Shared types and constants of the Pauli string state update block.
// ----------------------------------------------------------------------------
package pss_pkg;

  // amplitude format: two's complement, two integer bits
  localparam int AMP_BITS = 16;
  localparam int FRAC     = AMP_BITS - 2;
  localparam int PROD_W   = 2 * AMP_BITS;
  localparam int ACC_W    = 2 * AMP_BITS + 3;
  localparam int MASK_W   = 10;
  localparam int BIDX_W   = 10;
  localparam int CFG_AW   = 5;

  localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(1) <<< (FRAC - 1);
  localparam logic signed [ACC_W-1:0] AMP_MAXV = (ACC_W'(1) <<< (AMP_BITS - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] AMP_MINV = -(ACC_W'(1) <<< (AMP_BITS - 1));

  // function codes of an input transaction
  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_GATE   = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_CONTROL = 3'd1;
  localparam logic [2:0] REG_FLIP    = 3'd2;
  localparam logic [2:0] REG_PHASE   = 3'd3;
  localparam logic [2:0] REG_COEF_RE = 3'd4;
  localparam logic [2:0] REG_COEF_IM = 3'd5;
  localparam logic [2:0] REG_SINE_RE = 3'd6;
  localparam logic [2:0] REG_SINE_IM = 3'd7;

  typedef struct packed {
    logic [1:0]                 func;
    logic [BIDX_W-1:0]          basis_index;
    logic signed [AMP_BITS-1:0] in_re;
    logic signed [AMP_BITS-1:0] in_im;
  } pss_in_t;

  typedef struct packed {
    logic signed [AMP_BITS-1:0] out_re;
    logic signed [AMP_BITS-1:0] out_im;
    logic                       gate_done;
    logic                       saturated;
  } pss_out_t;

  typedef struct packed {
    logic                       gate_mode;
    logic [MASK_W-1:0]          control_bits;
    logic [MASK_W-1:0]          flip_bits;
    logic [MASK_W-1:0]          phase_bits;
    logic signed [AMP_BITS-1:0] coef_re;
    logic signed [AMP_BITS-1:0] coef_im;
    logic signed [AMP_BITS-1:0] sine_re;
    logic signed [AMP_BITS-1:0] sine_im;
  } pss_cfg_t;

  // control of the complex multiply-accumulate unit
  typedef struct packed {
    logic       clr;
    logic       mul_v;
    logic       dst;
    logic [1:0] quarter;
  } pss_mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_G_SCAN,
    ST_G_MUL,
    ST_G_ACC,
    ST_G_WR0,
    ST_G_WR1,
    ST_G_DONE
  } pss_state_t;

endpackage

[rtl/pss_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_cfg_regs
// APB-style register file holding the gate description.
// ----------------------------------------------------------------------------
module pss_cfg_regs
  import pss_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output pss_cfg_t          cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;
  pss_cfg_t   cfg_r;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];
  assign cfg     = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gate_mode    <= 1'b0;
      cfg_r.control_bits <= '0;
      cfg_r.flip_bits    <= '0;
      cfg_r.phase_bits   <= '0;
      cfg_r.coef_re      <= AMP_BITS'(1) <<< FRAC;
      cfg_r.coef_im      <= '0;
      cfg_r.sine_re      <= '0;
      cfg_r.sine_im      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:    cfg_r.gate_mode    <= pwdata[0];
        REG_CONTROL: cfg_r.control_bits <= pwdata[MASK_W-1:0];
        REG_FLIP:    cfg_r.flip_bits    <= pwdata[MASK_W-1:0];
        REG_PHASE:   cfg_r.phase_bits   <= pwdata[MASK_W-1:0];
        REG_COEF_RE: cfg_r.coef_re      <= pwdata[AMP_BITS-1:0];
        REG_COEF_IM: cfg_r.coef_im      <= pwdata[AMP_BITS-1:0];
        REG_SINE_RE: cfg_r.sine_re      <= pwdata[AMP_BITS-1:0];
        REG_SINE_IM: cfg_r.sine_im      <= pwdata[AMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_MODE:    prdata = 32'(cfg_r.gate_mode);
      REG_CONTROL: prdata = 32'(cfg_r.control_bits);
      REG_FLIP:    prdata = 32'(cfg_r.flip_bits);
      REG_PHASE:   prdata = 32'(cfg_r.phase_bits);
      REG_COEF_RE: prdata = 32'(unsigned'(cfg_r.coef_re));
      REG_COEF_IM: prdata = 32'(unsigned'(cfg_r.coef_im));
      REG_SINE_RE: prdata = 32'(unsigned'(cfg_r.sine_re));
      REG_SINE_IM: prdata = 32'(unsigned'(cfg_r.sine_im));
      default:     prdata = '0;
    endcase
  end

endmodule

[rtl/pss_amp_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_amp_mem
// Amplitude store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module pss_amp_mem
  import pss_pkg::*;
#(
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  logic [PROD_W-1:0]   wdata,
  input  logic                re,
  input  logic [ADDR_W-1:0]   raddr_a,
  input  logic [ADDR_W-1:0]   raddr_b,
  output logic [PROD_W-1:0]   rdata_a,
  output logic [PROD_W-1:0]   rdata_b
);

  logic [PROD_W-1:0] mem [(1 << ADDR_W)];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/pss_cmac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pss_cmac
// Complex multiplier with quarter-turn rotation, two exact accumulators,
// and round-half-up with saturation of both results.
// ----------------------------------------------------------------------------
module pss_cmac
  import pss_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  pss_mac_ctl_t               ctl,
  input  logic signed [AMP_BITS-1:0] a_re,
  input  logic signed [AMP_BITS-1:0] a_im,
  input  logic signed [AMP_BITS-1:0] b_re,
  input  logic signed [AMP_BITS-1:0] b_im,
  output logic [PROD_W-1:0]          res0,
  output logic [PROD_W-1:0]          res1,
  output logic                       sat0,
  output logic                       sat1
);

  logic signed [PROD_W-1:0] p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                     pv_r;
  logic                     pd_r;
  logic [1:0]               pq_r;
  logic signed [ACC_W-1:0]  acc_re_r [2];
  logic signed [ACC_W-1:0]  acc_im_r [2];
  logic signed [ACC_W-1:0]  t_re, t_im, add_re, add_im;
  logic signed [AMP_BITS-1:0] r0_re, r0_im, r1_re, r1_im;
  logic s0_re, s0_im, s1_re, s1_im;

  // product stage
  always_ff @(posedge clk) begin
    p_rr_r <= a_re * b_re;
    p_ii_r <= a_im * b_im;
    p_ri_r <= a_re * b_im;
    p_ir_r <= a_im * b_re;
    pd_r   <= ctl.dst;
    pq_r   <= ctl.quarter;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.mul_v;
    end
  end

  // complex product times (-i)^quarter
  always_comb begin
    t_re = ACC_W'(p_rr_r) - ACC_W'(p_ii_r);
    t_im = ACC_W'(p_ri_r) + ACC_W'(p_ir_r);
    unique case (pq_r)
      2'd0: begin add_re = t_re;  add_im = t_im;  end
      2'd1: begin add_re = t_im;  add_im = -t_re; end
      2'd2: begin add_re = -t_re; add_im = -t_im; end
      default: begin add_re = -t_im; add_im = t_re; end
    endcase
  end

  // accumulators
  always_ff @(posedge clk) begin
    if (ctl.clr) begin
      acc_re_r[0] <= '0;
      acc_im_r[0] <= '0;
      acc_re_r[1] <= '0;
      acc_im_r[1] <= '0;
    end else if (pv_r) begin
      acc_re_r[pd_r] <= acc_re_r[pd_r] + add_re;
      acc_im_r[pd_r] <= acc_im_r[pd_r] + add_im;
    end
  end

  function automatic logic [AMP_BITS:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    logic [AMP_BITS:0]       res;
    sh = (acc + HALF_LSB) >>> FRAC;
    if (sh > AMP_MAXV) begin
      res = {1'b1, AMP_MAXV[AMP_BITS-1:0]};
    end else if (sh < AMP_MINV) begin
      res = {1'b1, AMP_MINV[AMP_BITS-1:0]};
    end else begin
      res = {1'b0, sh[AMP_BITS-1:0]};
    end
    return res;
  endfunction

  // rounding and saturation of both results
  assign {s0_re, r0_re} = round_sat(acc_re_r[0]);
  assign {s0_im, r0_im} = round_sat(acc_im_r[0]);
  assign {s1_re, r1_re} = round_sat(acc_re_r[1]);
  assign {s1_im, r1_im} = round_sat(acc_im_r[1]);

  assign res0 = {r0_re, r0_im};
  assign res1 = {r1_re, r1_im};
  assign sat0 = s0_re | s0_im;
  assign sat1 = s1_re | s1_im;

endmodule

[rtl/pauli_string_state_update.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pauli_string_state_update
// State vector store with multi-controlled Pauli product and rotation gates.
// ----------------------------------------------------------------------------
// A write transaction is written to the store when it is accepted; a read
// is registered out of the store and returns its amplitude as one result.
// No new transaction is accepted until the current one completes. A gate
// transaction scans every index of the store once, and the scan reads each
// active entry and its partner. Each active entry, or pair when bits flip,
// then goes through four complex multiplies on the single shared multiplier,
// one accumulate and one write, plus one more write for the partner entry
// when bits flip. The single write port of the amplitude memory and the
// shared multiplier set the length of a gate. A gate whose control and flip
// qubits overlap finishes without a scan. The store needs no clearing after
// reset as long as the user writes entries before they are read; the block
// itself does not enforce this.
// ----------------------------------------------------------------------------
module pauli_string_state_update
  import pss_pkg::*;
#(
  parameter int NUM_QUBITS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pss_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pss_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int XW = (NUM_QUBITS > MASK_W) ? NUM_QUBITS : MASK_W;

  pss_cfg_t        cfg;
  pss_mac_ctl_t    mac_ctl;
  pss_state_t      state_r, state_nxt;
  logic [NUM_QUBITS-1:0] idx_r, idx_nxt, idx_pair;
  logic [1:0]      t_r, t_nxt;
  logic            sat_r, sat_nxt;
  logic            out_valid_r, out_valid_nxt;
  pss_out_t        out_data_r, out_data_nxt;

  logic [XW-1:0]         ctl_x, flp_x, phs_x, bidx_x;
  logic [NUM_QUBITS-1:0] ctl, flp, phs, pivot, bidx;
  logic [1:0]            g;
  logic                  in_acc, out_free, qual, last_idx, p0, p1;

  logic                  mem_we, mem_re;
  logic [NUM_QUBITS-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
  logic [PROD_W-1:0]     mem_wdata, mem_rdata_a, mem_rdata_b;
  logic [PROD_W-1:0]     res0, res1;
  logic                  sat0, sat1;
  logic signed [AMP_BITS-1:0] op_a_re, op_a_im, op_b_re, op_b_im;

  pss_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  pss_amp_mem #(.ADDR_W(NUM_QUBITS)) u_mem (
    .clk    (clk),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .re     (mem_re),
    .raddr_a(mem_raddr_a),
    .raddr_b(mem_raddr_b),
    .rdata_a(mem_rdata_a),
    .rdata_b(mem_rdata_b)
  );

  pss_cmac u_cmac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .a_re (op_a_re),
    .a_im (op_a_im),
    .b_re (op_b_re),
    .b_im (op_b_im),
    .res0 (res0),
    .res1 (res1),
    .sat0 (sat0),
    .sat1 (sat1)
  );

  // masks and index trimmed to the qubit count
  assign ctl_x  = XW'(cfg.control_bits);
  assign flp_x  = XW'(cfg.flip_bits);
  assign phs_x  = XW'(cfg.phase_bits);
  assign bidx_x = XW'(in_data.basis_index);
  assign ctl    = ctl_x[NUM_QUBITS-1:0];
  assign flp    = flp_x[NUM_QUBITS-1:0];
  assign phs    = phs_x[NUM_QUBITS-1:0];
  assign bidx   = bidx_x[NUM_QUBITS-1:0];

  // highest flipped qubit and quarter-turn count of Y factors
  always_comb begin
    pivot = '0;
    g     = 2'd0;
    for (int i = 0; i < NUM_QUBITS; i++) begin
      if (flp[i]) begin
        pivot = NUM_QUBITS'(1) << i;
      end
      g = g + 2'(flp[i] & phs[i]);
    end
  end

  // pair bookkeeping
  assign idx_pair = idx_r ^ flp;
  assign last_idx = (idx_r == '1);
  assign qual     = ((idx_r & ctl) == ctl) && ((idx_r & pivot) == '0);
  assign p0       = ^(idx_r & phs);
  assign p1       = ^(idx_pair & phs);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_data.func == FUNC_READ) begin
          state_nxt = ST_RD_WAIT;
        end else if (in_acc && in_data.func == FUNC_GATE) begin
          state_nxt = ((ctl & flp) != '0) ? ST_G_DONE : ST_G_SCAN;
        end
      end
      ST_RD_WAIT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_G_SCAN: begin
        if (qual) state_nxt = ST_G_MUL;
        else if (last_idx) state_nxt = ST_G_DONE;
      end
      ST_G_MUL: begin
        if (t_r == 2'd3) state_nxt = ST_G_ACC;
      end
      ST_G_ACC: state_nxt = ST_G_WR0;
      ST_G_WR0: begin
        if (flp != '0) state_nxt = ST_G_WR1;
        else state_nxt = last_idx ? ST_G_DONE : ST_G_SCAN;
      end
      ST_G_WR1: state_nxt = last_idx ? ST_G_DONE : ST_G_SCAN;
      ST_G_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    idx_nxt       = idx_r;
    t_nxt         = t_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r;
    mem_wdata     = res0;
    mem_re        = 1'b0;
    mem_raddr_a   = idx_r;
    mem_raddr_b   = idx_pair;
    mac_ctl       = '0;
    op_a_re       = $signed(mem_rdata_a[PROD_W-1:AMP_BITS]);
    op_a_im       = $signed(mem_rdata_a[AMP_BITS-1:0]);
    op_b_re       = cfg.coef_re;
    op_b_im       = cfg.coef_im;
    unique case (state_r)
      ST_IDLE: begin
        mem_raddr_a = bidx;
        idx_nxt     = '0;
        t_nxt       = 2'd0;
        sat_nxt     = 1'b0;
        if (in_acc && in_data.func == FUNC_WRITE) begin
          mem_we    = 1'b1;
          mem_waddr = bidx;
          mem_wdata = {in_data.in_re, in_data.in_im};
        end
        if (in_acc && in_data.func == FUNC_READ) begin
          mem_re = 1'b1;
        end
      end
      ST_RD_WAIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_re    = $signed(mem_rdata_a[PROD_W-1:AMP_BITS]);
          out_data_nxt.out_im    = $signed(mem_rdata_a[AMP_BITS-1:0]);
          out_data_nxt.gate_done = 1'b0;
          out_data_nxt.saturated = 1'b0;
        end
      end
      ST_G_SCAN: begin
        t_nxt = 2'd0;
        if (qual) begin
          mem_re      = 1'b1;
          mac_ctl.clr = 1'b1;
        end else if (!last_idx) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_G_MUL: begin
        // term schedule: dst0 gets terms 0,1 and dst1 gets terms 2,3
        mac_ctl.mul_v = 1'b1;
        mac_ctl.dst   = t_r[1];
        t_nxt         = t_r + 1'b1;
        unique case (t_r)
          2'd0: begin
            if (!cfg.gate_mode) begin
              op_a_re = $signed(mem_rdata_b[PROD_W-1:AMP_BITS]);
              op_a_im = $signed(mem_rdata_b[AMP_BITS-1:0]);
              mac_ctl.quarter = g + {p0, 1'b0};
            end
          end
          2'd1: begin
            op_a_re = $signed(mem_rdata_b[PROD_W-1:AMP_BITS]);
            op_a_im = $signed(mem_rdata_b[AMP_BITS-1:0]);
            op_b_re = cfg.gate_mode ? cfg.sine_re : '0;
            op_b_im = cfg.gate_mode ? cfg.sine_im : '0;
            mac_ctl.quarter = g + {p0, 1'b0} + 2'd3;
          end
          2'd2: begin
            if (cfg.gate_mode) begin
              op_a_re = $signed(mem_rdata_b[PROD_W-1:AMP_BITS]);
              op_a_im = $signed(mem_rdata_b[AMP_BITS-1:0]);
            end else begin
              mac_ctl.quarter = g + {p1, 1'b0};
            end
          end
          default: begin
            op_b_re = cfg.gate_mode ? cfg.sine_re : '0;
            op_b_im = cfg.gate_mode ? cfg.sine_im : '0;
            mac_ctl.quarter = g + {p1, 1'b0} + 2'd3;
          end
        endcase
      end
      ST_G_ACC: ;
      ST_G_WR0: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r;
        mem_wdata = res0;
        sat_nxt   = sat_r | sat0;
        if (flp == '0 && !last_idx) idx_nxt = idx_r + 1'b1;
      end
      ST_G_WR1: begin
        mem_we    = 1'b1;
        mem_waddr = idx_pair;
        mem_wdata = res1;
        sat_nxt   = sat_r | sat1;
        if (!last_idx) idx_nxt = idx_r + 1'b1;
      end
      ST_G_DONE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.out_re    = '0;
          out_data_nxt.out_im    = '0;
          out_data_nxt.gate_done = 1'b1;
          out_data_nxt.saturated = sat_r;
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      t_r         <= 2'd0;
      sat_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      t_r         <= t_nxt;
      sat_r       <= sat_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the memory is never written while a pair is being multiplied
  a_no_write_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_G_MUL || state_r == ST_G_ACC) |-> !mem_we)
    else $error("amplitude write during multiply");

  // four multiply steps lead into the accumulate step
  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_G_MUL && t_r == 2'd3) |=> (state_r == ST_G_ACC))
    else $error("multiply schedule broken");

  // an accepted read moves to the read wait state
  a_read_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.func == FUNC_READ) |=> (state_r == ST_RD_WAIT))
    else $error("read transaction lost");

  // a finished gate raises a completion result
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_G_DONE && out_free) |=> (out_valid && out_data.gate_done))
    else $error("gate completion missing");

endmodule
